/* hdl/mdcs_pkg.sv */
// Shared types and constants for the divisor-count maximum block.
// No dependencies; every other file in hdl/ depends on this package.
package mdcs_pkg;

  localparam int unsigned BEST_VALUE_W = 15;
  localparam int unsigned COUNT_W      = 8;

  // Handshake back from the iterative remainder unit.
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

  // Result of one divisor count, valid for one cycle with done.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } cnt_status_t;

endpackage

/* hdl/mdcs_if.sv */
// Valid/ready channels of the divisor-count maximum block.
// Depends on mdcs_pkg for the result field widths.
interface mdcs_in_if #(
  parameter int unsigned VALUE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface mdcs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mdcs_pkg::BEST_VALUE_W-1:0]    best_value;
  logic [mdcs_pkg::COUNT_W-1:0]         best_count;
  logic                                 found;

  modport source (output valid, output best_value, output best_count, output found,
                  input ready);
  modport sink   (input valid, input best_value, input best_count, input found,
                  output ready);
endinterface

/* hdl/mdcs_remainder.sv */
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on mdcs_pkg for the status struct.
module mdcs_remainder #(
  parameter int unsigned NW = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NW-1:0]         dividend_i,
  input  logic [NW-1:0]         divisor_i,
  output mdcs_pkg::rem_status_t status_o
);
  import mdcs_pkg::*;

  localparam int unsigned IW = $clog2(NW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [NW-1:0] rem_q, rem_d;
  logic [NW-1:0] shift_q, shift_d;
  logic [NW-1:0] div_q, div_d;
  logic [NW:0]   trial;
  logic [NW:0]   diff;

  assign trial = {rem_q, shift_q[NW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    idx_d   = idx_q;
    rem_d   = rem_q;
    shift_d = shift_q;
    div_d   = div_q;
    if (start_i) begin
      busy_d  = 1'b1;
      idx_d   = IW'(NW - 1);
      rem_d   = '0;
      shift_d = dividend_i;
      div_d   = divisor_i;
    end else if (busy_q) begin
      // restore when the trial is below the divisor
      rem_d   = (trial >= {1'b0, div_q}) ? diff[NW-1:0] : trial[NW-1:0];
      shift_d = {shift_q[NW-2:0], 1'b0};
      idx_d   = idx_q - 1'b1;
      if (idx_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    shift_q <= shift_d;
    div_q   <= div_d;
  end

  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

/* hdl/mdcs_count.sv */
// Divisor-count sequencer: trial divisors 1..sqrt(n) through its own remainder unit.
// Depends on mdcs_pkg and mdcs_remainder.
module mdcs_count #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output mdcs_pkg::cnt_status_t         status_o
);
  import mdcs_pkg::*;

  localparam int unsigned NW = VALUE_WIDTH - 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  logic [1:0]         state_q, state_d;
  logic               done_q, done_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [NW-1:0]      n_q, n_d;
  logic [NW-1:0]      d_q, d_d;
  logic [NW:0]        sq_q, sq_d;
  logic               rem_start;
  rem_status_t        rem_status;
  logic [COUNT_W:0]   sum;
  logic               past_root;

  assign past_root = (sq_q > {1'b0, n_q});
  assign rem_start = (state_q == ST_CHECK) && !past_root;
  // a perfect square root pairs with itself
  assign sum = {1'b0, total_q} + ((sq_q == {1'b0, n_q}) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));

  mdcs_remainder #(
    .NW(NW)
  ) u_remainder (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .status_o   (rem_status)
  );

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    total_d = total_q;
    n_d     = n_q;
    d_d     = d_q;
    sq_d    = sq_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          total_d = '0;
          if (value_i[VALUE_WIDTH-1] || (value_i == '0)) begin
            done_d = 1'b1;
          end else begin
            n_d     = value_i[NW-1:0];
            d_d     = NW'(1);
            sq_d    = (NW+1)'(1);
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (past_root) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (rem_status.done) begin
          if (rem_status.zero) begin
            total_d = sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
          end
          // (d+1)^2 = d^2 + 2d + 1
          sq_d    = sq_q + {d_q, 1'b1};
          d_d     = d_q + 1'b1;
          state_d = ST_CHECK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    n_q     <= n_d;
    d_q     <= d_d;
    sq_q    <= sq_d;
  end

  assign status_o.done  = done_q;
  assign status_o.count = total_q;

endmodule

/* hdl/max_divisor_count_select.sv */
// Divisor-count maximum over a set of signed values closed by an item marked last.
// A positive value n holds the input until its trial divisors 1..floor(sqrt(n)) have each
// run through the bit-serial remainder unit; a value of zero or below gets a count of zero
// without any trial. The last item also passes through TOP_EMIT to load the result
// register, waiting while that one is still held. Reset (rst_ni low, asynchronous)
// clears the running best and all handshake state. Depends on mdcs_pkg, mdcs_if, mdcs_count.
module max_divisor_count_select #(
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  mdcs_in_if.sink        in_i,
  mdcs_out_if.source     out_o
);
  import mdcs_pkg::*;

  localparam int unsigned NW    = VALUE_WIDTH - 1;
  localparam int unsigned EXT_W = NW + BEST_VALUE_W;

  localparam logic [1:0] TOP_IDLE = 2'd0;
  localparam logic [1:0] TOP_BUSY = 2'd1;
  localparam logic [1:0] TOP_EMIT = 2'd2;

  logic [1:0]              state_q, state_d;
  logic                    last_q, last_d;
  logic [BEST_VALUE_W-1:0] cand_q, cand_d;
  logic [BEST_VALUE_W-1:0] best_val_q, best_val_d;
  logic [COUNT_W-1:0]      best_cnt_q, best_cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [BEST_VALUE_W-1:0] out_val_q, out_val_d;
  logic [COUNT_W-1:0]      out_cnt_q, out_cnt_d;
  logic                    out_found_q, out_found_d;
  logic                    in_fire;
  logic                    out_free;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [EXT_W-1:0]        value_ext;
  cnt_status_t             cnt_status;

  assign value     = in_i.value;
  assign value_ext = {{BEST_VALUE_W{1'b0}}, value[NW-1:0]};
  assign in_i.ready = (state_q == TOP_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;

  mdcs_count #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_count (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_fire),
    .value_i  (value),
    .status_o (cnt_status)
  );

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    cand_d      = cand_q;
    best_val_d  = best_val_q;
    best_cnt_d  = best_cnt_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    out_found_d = out_found_q;
    unique case (state_q)
      TOP_IDLE: begin
        if (in_fire) begin
          last_d  = in_i.is_last;
          cand_d  = value_ext[BEST_VALUE_W-1:0];
          state_d = TOP_BUSY;
        end
      end
      TOP_BUSY: begin
        if (cnt_status.done) begin
          // strictly greater only: earlier value wins a tie
          if (cnt_status.count > best_cnt_q) begin
            best_cnt_d = cnt_status.count;
            best_val_d = cand_q;
          end
          state_d = last_q ? TOP_EMIT : TOP_IDLE;
        end
      end
      TOP_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_val_d   = best_val_q;
          out_cnt_d   = best_cnt_q;
          out_found_d = (best_cnt_q != '0);
          best_val_d  = '0;
          best_cnt_d  = '0;
          state_d     = TOP_IDLE;
        end
      end
      default: state_d = TOP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TOP_IDLE;
      out_valid_q <= 1'b0;
      best_val_q  <= '0;
      best_cnt_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      best_val_q  <= best_val_d;
      best_cnt_q  <= best_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q      <= last_d;
    cand_q      <= cand_d;
    out_val_q   <= out_val_d;
    out_cnt_q   <= out_cnt_d;
    out_found_q <= out_found_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.best_value = out_val_q;
  assign out_o.best_count = out_cnt_q;
  assign out_o.found      = out_found_q;

endmodule
